/* src/psu_pkg.sv */
// Package for the priority semaphore unit: sizes, operation and status codes,
// fixed deadline and count limits, and the waiter count saturation helper.
// No dependencies.
package psu_pkg;

  // Wait table depth and derived widths
  localparam int WAIT_SLOTS = 8;
  localparam int SLOT_W     = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int TOTAL_W    = $clog2(WAIT_SLOTS + 1);

  // Field widths
  localparam int KIND_W   = 2;
  localparam int TASK_W   = 8;
  localparam int PRIO_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int TICK_W   = 16;
  localparam int STATUS_W = 2;
  localparam int WAITERS_W = 4;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PEND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POST   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ISR     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd3;

  localparam logic [TICK_W-1:0]  NO_TIMEOUT_DEADLINE = 16'd65000;
  localparam logic [COUNT_W-1:0] COUNT_MAX           = 16'hFFFF;
  localparam logic [TICK_W-1:0]  TICK_WRAP_RESET     = 16'hFFFF;

  // Waiter count as reported, saturating at the field maximum
  function automatic logic [WAITERS_W-1:0] sat_waiters(input logic [TOTAL_W-1:0] t);
    logic [WAITERS_W-1:0] r;
    if (int'(t) > 15) r = 4'd15;
    else              r = WAITERS_W'(t);
    return r;
  endfunction

endpackage

/* src/psu_if.sv */
// Channel interfaces of the priority semaphore unit: request, result and
// configuration write channels. Depends on psu_pkg.
interface psu_in_if;
  logic                          valid;
  logic                          ready;
  logic [psu_pkg::KIND_W-1:0]    kind;
  logic                          in_isr;
  logic [psu_pkg::TASK_W-1:0]    task_id;
  logic [psu_pkg::PRIO_W-1:0]    task_priority;
  logic [psu_pkg::COUNT_W-1:0]   init_count;
  logic [psu_pkg::TICK_W-1:0]    timeout;
  logic [psu_pkg::TICK_W-1:0]    tick_now;

  modport source (output valid, kind, in_isr, task_id, task_priority, init_count,
                  timeout, tick_now, input ready);
  modport sink   (input valid, kind, in_isr, task_id, task_priority, init_count,
                  timeout, tick_now, output ready);
endinterface

interface psu_out_if;
  logic                           valid;
  logic                           ready;
  logic [psu_pkg::STATUS_W-1:0]   status;
  logic                           wake_valid;
  logic [psu_pkg::TASK_W-1:0]     wake_task;
  logic [psu_pkg::TICK_W-1:0]     wake_deadline;
  logic [psu_pkg::WAITERS_W-1:0]  waiters;

  modport source (output valid, status, wake_valid, wake_task, wake_deadline, waiters,
                  input ready);
  modport sink   (input valid, status, wake_valid, wake_task, wake_deadline, waiters,
                  output ready);
endinterface

interface psu_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [psu_pkg::TICK_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/priority_semaphore_unit.sv */
// Priority semaphore unit: counting semaphore with an 8-slot wait table; uses psu_pkg, psu_if.
// Create, pend on a nonzero count, refused calls and post with no waiters go from accept straight
// to the done step; a blocking pend takes a deadline step, then a scan that stops at the first free
// or matching slot or at the last slot; post with waiters scans every slot, then a post end step.
// One slot compare per cycle; one transaction in flight, the next accepted the cycle after the
// result loads. Reset (sync, rst_n low): count 0, table empty.
module priority_semaphore_unit (
  input  logic      clk,
  input  logic      rst_n,
  psu_in_if.sink    in_ch,
  psu_out_if.source out_ch,
  psu_cfg_if.sink   cfg_ch
);
  import psu_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DLINE    = 5'b00010,
    S_SCAN     = 5'b00100,
    S_POST_END = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Architectural state
  logic [TICK_W-1:0]  tick_wrap_r;
  logic [COUNT_W-1:0] sem_count_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TASK_W-1:0]  wtask_r [WAIT_SLOTS];
  logic [PRIO_W-1:0]  wprio_r [WAIT_SLOTS];

  // Captured request
  logic [KIND_W-1:0] op_kind_r;
  logic [TASK_W-1:0] op_tid_r;
  logic [PRIO_W-1:0] op_prio_r;
  logic              tmo_zero_r;
  logic [TICK_W-1:0] sum_r;

  // Scan unit
  logic [SLOT_W-1:0] idx_r;
  logic [SLOT_W-1:0] sel_r;
  logic [PRIO_W-1:0] best_r;
  logic              found_r;
  logic [TASK_W-1:0] cur_task;
  logic [PRIO_W-1:0] cur_prio;
  logic              scan_last;
  logic              slot_match;
  logic              slot_empty;

  // Working result and output register
  logic [STATUS_W-1:0]  res_status_r;
  logic                 res_wvalid_r;
  logic [TASK_W-1:0]    res_wtask_r;
  logic [TICK_W-1:0]    res_dl_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 out_wvalid_r;
  logic [TASK_W-1:0]    out_wtask_r;
  logic [TICK_W-1:0]    out_dl_r;
  logic [WAITERS_W-1:0] out_waiters_r;

  logic in_fire, out_fire, cfg_fire, out_free;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;
  assign cfg_fire = cfg_ch.valid;
  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.wake_valid    = out_wvalid_r;
  assign out_ch.wake_task     = out_wtask_r;
  assign out_ch.wake_deadline = out_dl_r;
  assign out_ch.waiters       = out_waiters_r;

  // Slot under the scan pointer
  assign cur_task   = wtask_r[idx_r];
  assign cur_prio   = wprio_r[idx_r];
  assign scan_last  = (idx_r == SLOT_W'(WAIT_SLOTS - 1));
  assign slot_match = (cur_task == op_tid_r);
  assign slot_empty = (cur_task == '0);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.kind)
            KIND_PEND: begin
              if (sem_count_r != '0 || in_ch.in_isr) state_nxt = S_DONE;
              else                                   state_nxt = S_DLINE;
            end
            KIND_POST: begin
              if (total_r == '0) state_nxt = S_DONE;
              else               state_nxt = S_SCAN;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_DLINE: state_nxt = S_SCAN;
      S_SCAN: begin
        if (op_kind_r == KIND_PEND) begin
          if (slot_match || slot_empty || scan_last) state_nxt = S_DONE;
        end else if (scan_last) begin
          state_nxt = S_POST_END;
        end
      end
      S_POST_END: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tick_wrap_r <= TICK_WRAP_RESET;
      sem_count_r <= '0;
      total_r     <= '0;
      for (int i = 0; i < WAIT_SLOTS; i++) begin
        wtask_r[i] <= '0;
        wprio_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) tick_wrap_r <= cfg_ch.data;
      // In the done step a taken result is replaced by the new one below
      if (out_fire && state_r != S_DONE) out_valid_r <= 1'b0;

      case (state_r)
        // Capture the transaction and settle the short cases
        S_IDLE: begin
          if (in_fire) begin
            op_kind_r    <= in_ch.kind;
            op_tid_r     <= in_ch.task_id;
            op_prio_r    <= in_ch.task_priority;
            tmo_zero_r   <= (in_ch.timeout == '0);
            sum_r        <= in_ch.tick_now + in_ch.timeout;
            res_status_r <= ST_OK;
            res_wvalid_r <= 1'b0;
            res_wtask_r  <= '0;
            res_dl_r     <= '0;
            idx_r        <= '0;
            sel_r        <= '0;
            best_r       <= '0;
            found_r      <= 1'b0;
            case (in_ch.kind)
              KIND_CREATE: begin
                if (in_ch.in_isr) begin
                  res_status_r <= ST_ISR;
                end else begin
                  sem_count_r <= in_ch.init_count;
                  total_r     <= '0;
                  for (int i = 0; i < WAIT_SLOTS; i++) begin
                    wtask_r[i] <= '0;
                    wprio_r[i] <= '0;
                  end
                end
              end
              KIND_PEND: begin
                if (sem_count_r != '0)  sem_count_r  <= sem_count_r - 1'b1;
                else if (in_ch.in_isr)  res_status_r <= ST_ISR;
                else                    res_status_r <= ST_BLOCKED;
              end
              KIND_POST: begin
                if (total_r == '0) begin
                  if (sem_count_r < COUNT_MAX) sem_count_r  <= sem_count_r + 1'b1;
                  else                         res_status_r <= ST_OVF;
                end
              end
              default: ;
            endcase
          end
        end
        // Wrapped wake deadline
        S_DLINE: begin
          if (tmo_zero_r)                res_dl_r <= NO_TIMEOUT_DEADLINE;
          else if (sum_r >= tick_wrap_r) res_dl_r <= sum_r - tick_wrap_r;
          else                           res_dl_r <= sum_r;
        end
        // One slot per cycle: insert on pend, best waiter on post
        S_SCAN: begin
          idx_r <= idx_r + 1'b1;
          if (op_kind_r == KIND_PEND) begin
            if (!slot_match && slot_empty) begin
              wtask_r[idx_r] <= op_tid_r;
              wprio_r[idx_r] <= op_prio_r;
              total_r        <= total_r + 1'b1;
            end
          end else if (!slot_empty && cur_prio >= best_r) begin
            best_r  <= cur_prio;
            sel_r   <= idx_r;
            found_r <= 1'b1;
          end
        end
        // Release the chosen waiter
        S_POST_END: begin
          if (found_r) begin
            res_wvalid_r   <= 1'b1;
            res_wtask_r    <= wtask_r[sel_r];
            wtask_r[sel_r] <= '0;
            wprio_r[sel_r] <= '0;
          end
          total_r <= total_r - 1'b1;
        end
        // Load the result register
        S_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= res_status_r;
            out_wvalid_r  <= res_wvalid_r;
            out_wtask_r   <= res_wtask_r;
            out_dl_r      <= res_dl_r;
            out_waiters_r <= sat_waiters(total_r);
          end
        end
        default: ;
      endcase
    end
  end

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(total_r) <= WAIT_SLOTS) else $error("waiter total above table depth");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the done step");

  a_wake_is_post: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_wvalid_r) |-> (out_status_r == ST_OK && out_dl_r == '0))
    else $error("wakeup result carries a status or deadline");

  a_wake_only_post: assert property (@(posedge clk) disable iff (!rst_n)
    res_wvalid_r |-> (op_kind_r == KIND_POST))
    else $error("wakeup flagged for a non-post transaction");

endmodule
